/* rtl/tpt_pkg.sv */
package tpt_pkg;

  // Elapsed tick counter width
  localparam int TICK_COUNT_WIDTH = 32;

  // Field and register widths
  localparam int SAMPLE_W = 10;
  localparam int RPM_W    = 32;
  localparam int TPR_W    = 8;
  localparam int TPM_W    = 32;
  localparam int THR_W    = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_TEETH_PER_REV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MINUTE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD  = 2'd2;

  localparam logic [TPR_W-1:0] TPR_RESET = 8'd3;
  localparam logic [TPM_W-1:0] TPM_RESET = 32'd60000000;
  localparam logic [THR_W-1:0] THR_RESET = 10'd0;

  // Job queue between classifier and divider; depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Divider step counter
  localparam int STEP_CNT_W = $clog2(RPM_W);

  // One revolution to be converted to rpm
  typedef struct packed {
    logic [TPM_W-1:0]            dividend;
    logic [TICK_COUNT_WIDTH-1:0] divisor;
    logic                        sat;
  } job_t;

endpackage

/* rtl/tpt_if.sv */
interface tpt_in_if;
  logic                          valid;
  logic                          ready;
  logic [tpt_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tpt_out_if;
  logic                       valid;
  logic                       ready;
  logic [tpt_pkg::RPM_W-1:0]  rpm;
  logic                       saturated;

  modport source (output valid, output rpm, output saturated, input ready);
  modport sink   (input valid, input rpm, input saturated, output ready);
endinterface

/* rtl/tpt_front.sv */
module tpt_front (
  input  logic                              clk,
  input  logic                              rst_n,
  tpt_in_if.sink                            in_ch,
  input  logic                              cfg_we,
  input  logic [tpt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tpt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              q_full,
  output logic                              q_push,
  output tpt_pkg::job_t                     q_job
);

  localparam int W = tpt_pkg::TICK_COUNT_WIDTH;

  logic [tpt_pkg::TPR_W-1:0] tpr_r;
  logic [tpt_pkg::TPM_W-1:0] tpm_r;
  logic [tpt_pkg::THR_W-1:0] thr_r;

  logic [tpt_pkg::TPR_W-1:0] tc_r, tc_nxt, tc_inc;
  logic                      armed_r, armed_nxt;
  logic [W-1:0]              el_r, el_nxt, el_inc;
  logic                      accept, above, tooth, emit;

  // Stall only when the job queue has no room
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Classify the sample
  assign el_inc = (el_r == {W{1'b1}}) ? el_r : el_r + W'(1);
  assign above  = in_ch.sample > thr_r;
  assign tooth  = above && armed_r;
  assign tc_inc = tc_r + tpt_pkg::TPR_W'(1);
  assign emit   = tooth && (tc_inc >= tpr_r);

  always_comb begin
    armed_nxt = armed_r;
    tc_nxt    = tc_r;
    el_nxt    = el_r;
    if (accept) begin
      el_nxt = emit ? '0 : el_inc;
      if (!above) begin
        armed_nxt = 1'b1;
      end else if (armed_r) begin
        armed_nxt = 1'b0;
        tc_nxt    = emit ? '0 : tc_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b1;
      tc_r    <= '0;
      el_r    <= '0;
    end else begin
      armed_r <= armed_nxt;
      tc_r    <= tc_nxt;
      el_r    <= el_nxt;
    end
  end

  // Hand a finished revolution to the divider
  assign q_push         = accept && emit;
  assign q_job.dividend = tpm_r;
  assign q_job.divisor  = el_inc;
  assign q_job.sat      = (el_inc == {W{1'b1}});

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpr_r <= tpt_pkg::TPR_RESET;
      tpm_r <= tpt_pkg::TPM_RESET;
      thr_r <= tpt_pkg::THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpt_pkg::CFG_TEETH_PER_REV:    tpr_r <= cfg_wdata[tpt_pkg::TPR_W-1:0];
        tpt_pkg::CFG_TICKS_PER_MINUTE: tpm_r <= cfg_wdata[tpt_pkg::TPM_W-1:0];
        tpt_pkg::CFG_LEVEL_THRESHOLD:  thr_r <= cfg_wdata[tpt_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/tpt_queue.sv */
module tpt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tpt_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output tpt_pkg::job_t  pop_job,
  output logic           empty
);

  tpt_pkg::job_t                mem_r [tpt_pkg::QUEUE_DEPTH];
  logic [tpt_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [tpt_pkg::QCNT_W-1:0]   cnt_r;

  assign full    = (cnt_r == tpt_pkg::QCNT_W'(tpt_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + tpt_pkg::QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + tpt_pkg::QPTR_W'(1);
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + tpt_pkg::QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - tpt_pkg::QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* rtl/tpt_div.sv */
module tpt_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  tpt_pkg::job_t  q_job,
  output logic           q_pop,
  tpt_out_if.source      out_ch
);

  localparam int W = tpt_pkg::TICK_COUNT_WIDTH;
  localparam int Q = tpt_pkg::RPM_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [Q-1:0]                    quo_r, quo_nxt;
  logic [W-1:0]                    rem_r, rem_nxt;
  logic [W-1:0]                    dvs_r, dvs_nxt;
  logic                            sat_r, sat_nxt;
  logic [tpt_pkg::STEP_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [Q-1:0]                    out_rpm_r, out_rpm_nxt;
  logic                            out_sat_r, out_sat_nxt;

  logic [W:0] trial, diff;
  logic       ge, slot_free;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[Q-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  assign slot_free = !out_valid_r || out_ch.ready;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    sat_nxt       = sat_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_rpm_nxt   = out_rpm_r;
    out_sat_nxt   = out_sat_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          quo_nxt   = q_job.dividend;
          rem_nxt   = '0;
          dvs_nxt   = q_job.divisor;
          sat_nxt   = q_job.sat;
          cnt_nxt   = tpt_pkg::STEP_CNT_W'(Q - 1);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        rem_nxt = ge ? diff[W-1:0] : trial[W-1:0];
        quo_nxt = {quo_r[Q-2:0], ge};
        cnt_nxt = cnt_r - tpt_pkg::STEP_CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // Wait for the output register to free up
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_rpm_nxt   = quo_r;
          out_sat_nxt   = sat_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
    sat_r     <= sat_nxt;
    cnt_r     <= cnt_nxt;
    out_rpm_r <= out_rpm_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.rpm       = out_rpm_r;
  assign out_ch.saturated = out_sat_r;

endmodule

/* rtl/tooth_period_tachometer.sv */
// Channel  Dir  Beat payload             Handshake
// in_ch    in   sample[9:0]              valid/ready, taken when both high
// out_ch   out  rpm[31:0], saturated     valid/ready, taken when both high
// cfg_*    in   cfg_index, cfg_wdata     write on cfg_we, no wait
//
// A sample is taken every cycle while the job queue has room; once the queue
// is full every sample stalls, including one that would end no revolution.
// Each revolution goes through the divider as a pop, 32 restoring steps and an
// output load; the single radix-2 loop finishes one before it pops the next.
// Synchronous active-low reset: armed, zero teeth, zero ticks, empty queue.
// A stalled result holds in the output register while the next divide runs.
module tooth_period_tachometer (
  input  logic                            clk,
  input  logic                            rst_n,
  tpt_in_if.sink                          in_ch,
  tpt_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [tpt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  logic           q_push, q_pop, q_full, q_empty;
  tpt_pkg::job_t  push_job, pop_job;

  tpt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  tpt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  tpt_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_job   (pop_job),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("job pushed into full queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job popped from empty queue");

  // A pushed job is visible to the divider next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> !q_empty)
    else $error("pushed job lost");

endmodule
